// ----- hw/rtl/fxbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// fxbcd_pkg
// Shared types, constants and elaboration helpers for the fixed-point to
// packed bcd codec and its digit cells.
// ----------------------------------------------------------------------------
package fxbcd_pkg;

    // default sizes of the codec
    localparam int MAX_DIGITS_DEF    = 15;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF    = 48;

    // packed bcd word
    localparam int BCD_BITS    = 64;
    localparam int BCD_NIBBLES = BCD_BITS / 4;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 4;

    // what a digit cell does in one cycle
    typedef enum logic [2:0] {
        CELL_HOLD        = 3'd0,
        CELL_LOAD        = 3'd1,
        CELL_DABBLE_UP   = 3'd2,
        CELL_SHIFT_DIGIT = 3'd3,
        CELL_DABBLE_DOWN = 3'd4
    } cell_op_t;

    // powers of ten by fraction digit count
    localparam logic [63:0] POW10 [16] = '{
        64'd1,
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000
    };

    // bits needed for the largest value n nibbles of 0..15 can weigh in decimal
    function automatic int bcd_value_bits(input int n);
        longint unsigned ones;
        ones = 0;
        for (int k = 0; k < n; k++) begin
            ones = ones * 10 + 1;
        end
        return $clog2(ones * 15 + 1);
    endfunction

endpackage

// ----- hw/rtl/fxbcd_cell.sv -----
// ----------------------------------------------------------------------------
// fxbcd_cell
// One bcd digit of the conversion chain: holds, loads, shifts a bit up with
// add-3, shifts a bit down with subtract-3, or passes its digit one place up.
// ----------------------------------------------------------------------------
module fxbcd_cell (
    input  logic                 aclk,
    input  fxbcd_pkg::cell_op_t  op,
    input  logic [3:0]           load_digit,
    input  logic [3:0]           lower_digit,
    input  logic                 lower_carry,
    input  logic                 upper_bit,
    output logic [3:0]           digit,
    output logic                 carry_out,
    output logic                 low_bit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;
    logic [3:0] raw;

    always_comb begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        raw = {upper_bit, digit_reg[3:1]};
        case (op)
            fxbcd_pkg::CELL_HOLD:        digit_next = digit_reg;
            fxbcd_pkg::CELL_LOAD:        digit_next = load_digit;
            fxbcd_pkg::CELL_DABBLE_UP:   digit_next = {adj[2:0], lower_carry};
            fxbcd_pkg::CELL_SHIFT_DIGIT: digit_next = lower_digit;
            // odd upper neighbor adds five here, the shifted-in bit gave eight
            fxbcd_pkg::CELL_DABBLE_DOWN: digit_next = upper_bit ? raw - 4'd3 : raw;
            default:                     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit     = digit_reg;
    assign carry_out = adj[3];
    assign low_bit   = digit_reg[0];

endmodule

// ----- hw/rtl/fixed_to_packed_bcd_codec.sv -----
// ----------------------------------------------------------------------------
// fixed_to_packed_bcd_codec
// pack: load, dabble integer bits, check overflow, shift in fraction digits
// unpack: load, drain both digit groups, adjust, divide, saturate
// one request at a time, next request can be taken in the cycle after the result
// is registered; the digit chain moves one bit or one digit per cycle
// reset clears control and sets digit_count 8, fraction_digits 2
// ----------------------------------------------------------------------------
module fixed_to_packed_bcd_codec #(
    parameter int MAX_DIGITS    = fxbcd_pkg::MAX_DIGITS_DEF,
    parameter int FRACTION_BITS = fxbcd_pkg::FRACTION_BITS_DEF,
    parameter int VALUE_BITS    = fxbcd_pkg::VALUE_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [fxbcd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fxbcd_pkg::CFG_DATA_BITS-1:0]     cfg_data,

    // request channel
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // fixed_value, bcd_in
    input  logic [((VALUE_BITS + fxbcd_pkg::BCD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // op
    input  logic [1:0]                              s_tuser,

    // result channel
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // bcd_out, value_out
    output logic [((VALUE_BITS + fxbcd_pkg::BCD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // overflow
    output logic [0:0]                              m_tuser
);

    // ------------------------------------------------------------------
    // sizes
    // ------------------------------------------------------------------
    localparam int BCD_BITS    = fxbcd_pkg::BCD_BITS;
    localparam int NIB         = fxbcd_pkg::BCD_NIBBLES;
    localparam int DATA_BITS   = ((VALUE_BITS + BCD_BITS + 7) / 8) * 8;
    localparam int INT_BITS    = VALUE_BITS - FRACTION_BITS;
    // decimal digits of the largest integer part, rounded up
    localparam int IP_DIGITS   = (INT_BITS * 5 + 15) / 16;
    localparam int NCELL       = (MAX_DIGITS > IP_DIGITS) ? MAX_DIGITS : IP_DIGITS;
    // bit steps to drain the chain on unpack
    localparam int UNPACK_BITS = fxbcd_pkg::bcd_value_bits(MAX_DIGITS);
    // one spare bit for the carry and the doubled remainder
    localparam int ACC_BITS    = UNPACK_BITS + 1;
    localparam int FULL_BITS   = ACC_BITS + FRACTION_BITS;
    localparam int MAG_BITS    = (FULL_BITS > VALUE_BITS) ? FULL_BITS : VALUE_BITS;
    localparam int STEP_A      = (INT_BITS > UNPACK_BITS) ? INT_BITS : UNPACK_BITS;
    localparam int STEP_B      = (STEP_A > FRACTION_BITS) ? STEP_A : FRACTION_BITS;
    localparam int STEP_MAX    = (STEP_B > NIB) ? STEP_B : NIB;
    localparam int CNT_BITS    = $clog2(STEP_MAX + 1);

    // op codes
    localparam logic [1:0] OP_PACK_UNSIGNED   = 2'd0;
    localparam logic [1:0] OP_PACK_SIGNED     = 2'd1;
    localparam logic [1:0] OP_UNPACK_UNSIGNED = 2'd2;
    localparam logic [1:0] OP_UNPACK_SIGNED   = 2'd3;

    // register indexes and reset values
    localparam logic [fxbcd_pkg::CFG_INDEX_BITS-1:0] REG_DIGIT_COUNT     = 2'd0;
    localparam logic [fxbcd_pkg::CFG_INDEX_BITS-1:0] REG_FRACTION_DIGITS = 2'd1;
    localparam logic [fxbcd_pkg::CFG_DATA_BITS-1:0]  DIGIT_COUNT_RESET     = 4'd8;
    localparam logic [fxbcd_pkg::CFG_DATA_BITS-1:0]  FRACTION_DIGITS_RESET = 4'd2;

    typedef enum logic [8:0] {
        ST_IDLE          = 9'b000000001,
        ST_PACK_DABBLE   = 9'b000000010,
        ST_PACK_CHECK    = 9'b000000100,
        ST_PACK_FRAC     = 9'b000001000,
        ST_UNPACK_DABBLE = 9'b000010000,
        ST_UNPACK_ADJUST = 9'b000100000,
        ST_UNPACK_DIVIDE = 9'b001000000,
        ST_UNPACK_SAT    = 9'b010000000,
        ST_FINISH        = 9'b100000000
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    logic [3:0] digit_count_reg;
    logic [3:0] fraction_digits_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg     <= DIGIT_COUNT_RESET;
            fraction_digits_reg <= FRACTION_DIGITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DIGIT_COUNT:     digit_count_reg     <= cfg_data;
                REG_FRACTION_DIGITS: fraction_digits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective digit counts: clamp to MAX_DIGITS, fraction no longer than field
    logic [3:0] nd;
    logic [3:0] nf;
    logic [3:0] ni;

    assign nd = (int'(digit_count_reg) > MAX_DIGITS) ? 4'(MAX_DIGITS) : digit_count_reg;
    assign nf = (fraction_digits_reg > nd) ? nd : fraction_digits_reg;
    assign ni = nd - nf;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic                  in_accept;
    logic                  in_unpack;
    logic                  in_signed;
    logic [VALUE_BITS-1:0] in_value;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  in_neg;
    logic [BCD_BITS-1:0]   in_bcd;
    logic [3:0]            in_sign_nibble;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_unpack = (s_tuser == OP_UNPACK_UNSIGNED) || (s_tuser == OP_UNPACK_SIGNED);
    assign in_signed = (s_tuser == OP_PACK_SIGNED) || (s_tuser == OP_UNPACK_SIGNED);
    assign in_value  = s_tdata[VALUE_BITS-1:0];
    assign in_neg    = in_value[VALUE_BITS-1];
    // most negative value keeps its own pattern, which is its magnitude
    assign in_mag    = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
    assign in_bcd    = s_tdata[VALUE_BITS +: BCD_BITS];
    // sign nibble sits just above the digits
    assign in_sign_nibble = in_bcd[{nd, 2'b00} +: 4];

    // ------------------------------------------------------------------
    // working registers
    // ------------------------------------------------------------------
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [CNT_BITS-1:0]      cnt_next;
    logic                     unpack_reg;
    logic                     signed_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic [INT_BITS-1:0]      int_sr_reg;     // integer bits fed msb first on pack
    logic [FRACTION_BITS-1:0] frac_reg;       // binary fraction left to expand
    logic [ACC_BITS-1:0]      acc_ip_reg;     // integer part gathered on unpack
    logic [ACC_BITS-1:0]      acc_f_reg;      // decimal fraction, then remainder
    logic [FRACTION_BITS-1:0] bits_reg;       // binary fraction quotient bits
    logic [VALUE_BITS-1:0]    mag_reg;        // saturated magnitude

    // ------------------------------------------------------------------
    // digit chain
    // ------------------------------------------------------------------
    fxbcd_pkg::cell_op_t cell_op;
    logic [3:0]          cell_digit       [NCELL];
    logic [3:0]          cell_load        [NCELL];
    logic [3:0]          cell_lower_digit [NCELL];
    logic [NCELL-1:0]    cell_lower_carry;
    logic [NCELL-1:0]    cell_upper;
    logic [NCELL-1:0]    cell_carry;
    logic [NCELL-1:0]    cell_low;

    // next fraction digit: multiply the binary fraction by ten
    logic [FRACTION_BITS+3:0] frac_prod;
    logic [3:0]               frac_digit;

    assign frac_prod  = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1);
    assign frac_digit = frac_prod[FRACTION_BITS+3:FRACTION_BITS];

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        if (i == 0) begin : g_first
            // bottom cell takes the serial integer bit and the new fraction digit
            assign cell_lower_carry[i] = int_sr_reg[INT_BITS-1];
            assign cell_lower_digit[i] = frac_digit;
        end else begin : g_rest
            assign cell_lower_carry[i] = cell_carry[i-1];
            assign cell_lower_digit[i] = cell_digit[i-1];
        end

        if (i == NCELL - 1) begin : g_top
            assign cell_upper[i] = 1'b0;
        end else begin : g_mid
            // the chain is cut below the lowest integer digit on unpack
            assign cell_upper[i] = (i + 1 == int'(nf)) ? 1'b0 : cell_low[i+1];
        end

        if (i < NIB) begin : g_loadable
            // unpack loads digits inside the field, pack starts from zero
            assign cell_load[i] = (!in_unpack || i >= int'(nd)) ? 4'd0 : in_bcd[4*i +: 4];
        end else begin : g_extra
            assign cell_load[i] = 4'd0;
        end

        fxbcd_cell u_cell (
            .aclk        (aclk),
            .op          (cell_op),
            .load_digit  (cell_load[i]),
            .lower_digit (cell_lower_digit[i]),
            .lower_carry (cell_lower_carry[i]),
            .upper_bit   (cell_upper[i]),
            .digit       (cell_digit[i]),
            .carry_out   (cell_carry[i]),
            .low_bit     (cell_low[i])
        );
    end

    // chain digits as a packed word, lowest cell in the lowest nibble
    logic [BCD_BITS-1:0] cells_word;

    for (genvar n = 0; n < NIB; n++) begin : g_word
        if (n < NCELL) begin : g_used
            assign cells_word[4*n +: 4] = cell_digit[n];
        end else begin : g_unused
            assign cells_word[4*n +: 4] = 4'd0;
        end
    end

    // overflow on pack: a nonzero digit at or above the integer digit count;
    // on unpack the integer group drains out of the cell at the cut
    logic digit_over;
    logic unpack_ip_bit;
    logic unpack_f_bit;

    always_comb begin
        digit_over    = 1'b0;
        unpack_ip_bit = 1'b0;
        for (int i = 0; i < NCELL; i++) begin
            if (i >= int'(ni) && cell_digit[i] != 4'd0) begin
                digit_over = 1'b1;
            end
            if (i == int'(nf)) begin
                unpack_ip_bit = cell_low[i];
            end
        end
    end

    assign unpack_f_bit = (nf != 4'd0) && cell_low[0];

    // ------------------------------------------------------------------
    // unpack arithmetic
    // ------------------------------------------------------------------
    logic [63:0]          den_full;
    logic [ACC_BITS-1:0]  den;
    logic [ACC_BITS-1:0]  rem2;
    logic [MAG_BITS-1:0]  full_mag;
    logic [MAG_BITS-1:0]  limit_base;
    logic [MAG_BITS-1:0]  limit;
    logic                 sat;

    assign den_full   = fxbcd_pkg::POW10[nf];
    assign den        = den_full[ACC_BITS-1:0];
    assign rem2       = {acc_f_reg[ACC_BITS-2:0], 1'b0};
    assign full_mag   = MAG_BITS'({acc_ip_reg, bits_reg});
    assign limit_base = MAG_BITS'(1) << (VALUE_BITS - 1);
    // negative results reach one step further
    assign limit      = neg_reg ? limit_base : limit_base - MAG_BITS'(1);
    assign sat        = full_mag > limit;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic out_load;
    logic m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cell_op    = fxbcd_pkg::CELL_HOLD;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    cell_op    = fxbcd_pkg::CELL_LOAD;
                    cnt_next   = '0;
                    state_next = in_unpack ? ST_UNPACK_DABBLE : ST_PACK_DABBLE;
                end
            end
            // binary integer part into the chain, one bit per cycle
            ST_PACK_DABBLE: begin
                cell_op  = fxbcd_pkg::CELL_DABBLE_UP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(INT_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_PACK_CHECK;
                end
            end
            ST_PACK_CHECK: begin
                state_next = (nf == 4'd0) ? ST_FINISH : ST_PACK_FRAC;
            end
            // each fraction digit pushes the chain up one nibble
            ST_PACK_FRAC: begin
                cell_op  = fxbcd_pkg::CELL_SHIFT_DIGIT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == CNT_BITS'(nf)) begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            // both digit groups drain to binary, one bit per cycle
            ST_UNPACK_DABBLE: begin
                cell_op  = fxbcd_pkg::CELL_DABBLE_DOWN;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(UNPACK_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_UNPACK_ADJUST;
                end
            end
            ST_UNPACK_ADJUST: begin
                state_next = ST_UNPACK_DIVIDE;
            end
            // restoring division of the decimal fraction by its denominator
            ST_UNPACK_DIVIDE: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(FRACTION_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_UNPACK_SAT;
                end
            end
            ST_UNPACK_SAT: begin
                state_next = ST_FINISH;
            end
            // wait here while the result register is full and not being taken
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath, no reset needed: every field is written before it is read
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    unpack_reg <= in_unpack;
                    signed_reg <= in_signed;
                    int_sr_reg <= in_mag[VALUE_BITS-1:FRACTION_BITS];
                    frac_reg   <= in_mag[FRACTION_BITS-1:0];
                    acc_ip_reg <= '0;
                    acc_f_reg  <= '0;
                    bits_reg   <= '0;
                    if (in_unpack) begin
                        // any nonzero sign nibble means negative
                        neg_reg <= in_signed && (in_sign_nibble != 4'd0);
                        ovf_reg <= 1'b0;
                    end else begin
                        // a negative value never fits an unsigned field
                        neg_reg <= in_neg;
                        ovf_reg <= in_neg && !in_signed;
                    end
                end
            end
            ST_PACK_DABBLE: begin
                int_sr_reg <= {int_sr_reg[INT_BITS-2:0], 1'b0};
            end
            ST_PACK_CHECK: begin
                ovf_reg <= ovf_reg || digit_over;
            end
            ST_PACK_FRAC: begin
                frac_reg <= frac_prod[FRACTION_BITS-1:0];
            end
            ST_UNPACK_DABBLE: begin
                acc_ip_reg <= {1'b0, unpack_ip_bit, acc_ip_reg[UNPACK_BITS-1:1]};
                acc_f_reg  <= {1'b0, unpack_f_bit, acc_f_reg[UNPACK_BITS-1:1]};
            end
            // out-of-range nibbles can push the fraction past one whole unit
            ST_UNPACK_ADJUST: begin
                if (acc_f_reg >= den) begin
                    acc_f_reg  <= acc_f_reg - den;
                    acc_ip_reg <= acc_ip_reg + ACC_BITS'(1);
                end
            end
            ST_UNPACK_DIVIDE: begin
                if (rem2 >= den) begin
                    acc_f_reg <= rem2 - den;
                    bits_reg  <= {bits_reg[FRACTION_BITS-2:0], 1'b1};
                end else begin
                    acc_f_reg <= rem2;
                    bits_reg  <= {bits_reg[FRACTION_BITS-2:0], 1'b0};
                end
            end
            ST_UNPACK_SAT: begin
                ovf_reg <= sat;
                mag_reg <= sat ? limit[VALUE_BITS-1:0] : full_mag[VALUE_BITS-1:0];
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [BCD_BITS-1:0]   sign_word;
    logic [BCD_BITS-1:0]   pack_word;
    logic [VALUE_BITS-1:0] signed_value;
    logic [BCD_BITS-1:0]   bcd_out_reg;
    logic [VALUE_BITS-1:0] value_out_reg;
    logic                  ovf_out_reg;

    assign sign_word    = BCD_BITS'(1) << {nd, 2'b00};
    // overflow clears the whole word, sign nibble included
    assign pack_word    = ovf_reg ? '0
                        : (cells_word | ((signed_reg && neg_reg) ? sign_word : '0));
    assign signed_value = neg_reg ? (~mag_reg + VALUE_BITS'(1)) : mag_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            bcd_out_reg   <= unpack_reg ? '0 : pack_word;
            value_out_reg <= unpack_reg ? signed_value : '0;
            ovf_out_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_BITS'({value_out_reg, bcd_out_reg});
    assign m_tuser  = ovf_out_reg;

endmodule

// ----- bench/tb_fixed_to_packed_bcd_codec.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_to_packed_bcd_codec
// Self-checking bench for the fixed-point / packed bcd codec. A directed
// table covers field extremes, every operation and the corner cases of
// both directions under several digit settings. Random requests under a
// series of digit settings follow. Each result is checked field by field
// against its table row or a bit-exact predictor. Sender bursts and receiver
// stalls are random; one long receiver hold-off backs up the request side.
// ----------------------------------------------------------------------------
module tb_fixed_to_packed_bcd_codec;

    timeunit 1ns;
    timeprecision 1ps;

    import fxbcd_pkg::*;

    // sizes as seen at the ports
    localparam int VALUE_W   = VALUE_BITS_DEF;
    localparam int FRAC_W    = FRACTION_BITS_DEF;
    localparam int MAX_DIGIT = MAX_DIGITS_DEF;
    localparam int DATA_W    = ((VALUE_W + BCD_BITS + 7) / 8) * 8;

    localparam logic [63:0] SIGN_WEIGHT = 64'd1 << (VALUE_W - 1);
    localparam logic [63:0] FRAC_MASK   = (64'd1 << FRAC_W) - 64'd1;

    // register indexes of the configuration channel
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIGIT_COUNT     = 0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRACTION_DIGITS = 1;

    // stall watchdog and run shape
    localparam int IDLE_LIMIT     = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_OFF_AT    = 300;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_REQUESTS = 100;

    typedef enum logic [1:0] {
        OP_PACK_UNSIGNED   = 2'd0,
        OP_PACK_SIGNED     = 2'd1,
        OP_UNPACK_UNSIGNED = 2'd2,
        OP_UNPACK_SIGNED   = 2'd3
    } codec_op_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_style_t;

    typedef struct packed {
        logic [BCD_BITS-1:0] bcd;
        logic [VALUE_W-1:0]  value;
        logic                overflow;
    } codec_result_t;

    // one directed request; want_* only used when known is set
    typedef struct packed {
        logic [3:0]          digits;
        logic [3:0]          fraction;
        codec_op_t           op;
        logic [VALUE_W-1:0]  fixed_value;
        logic [BCD_BITS-1:0] bcd_in;
        logic                known;
        logic [BCD_BITS-1:0] want_bcd;
        logic [VALUE_W-1:0]  want_value;
        logic                want_overflow;
    } request_row_t;

    localparam int DIRECTED_COUNT = 27;

    localparam request_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // reset setting: 8 digits, 2 after the point
        '{4'd8, 4'd2, OP_PACK_UNSIGNED, 48'h0000_0000_0000, 64'h0,
          1'b1, 64'h0, 48'h0, 1'b0},
        '{4'd8, 4'd2, OP_PACK_UNSIGNED, 48'h0000_0001_8000, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 64'h150, 48'h0, 1'b0},
        // negative into unsigned pack does not fit
        '{4'd8, 4'd2, OP_PACK_UNSIGNED, 48'hFFFF_FFFF_0000, 64'h0,
          1'b1, 64'h0, 48'h0, 1'b1},
        '{4'd8, 4'd2, OP_PACK_SIGNED, 48'hFFFF_FFFE_8000, 64'h0,
          1'b1, 64'h1_0000_0150, 48'h0, 1'b0},
        // tiny negative truncates to zero but keeps its sign nibble
        '{4'd8, 4'd2, OP_PACK_SIGNED, 48'hFFFF_FFFF_FFFF, 64'h0,
          1'b1, 64'h1_0000_0000, 48'h0, 1'b0},
        // 1000000 needs seven integer digits, only six there
        '{4'd8, 4'd2, OP_PACK_UNSIGNED, 48'h000F_4240_0000, 64'h0,
          1'b1, 64'h0, 48'h0, 1'b1},
        '{4'd8, 4'd2, OP_PACK_UNSIGNED, 48'h000F_423F_8000, 64'h0,
          1'b1, 64'h9999_9950, 48'h0, 1'b0},
        '{4'd8, 4'd2, OP_PACK_UNSIGNED, 48'h7FFF_FFFF_FFFF, 64'h0,
          1'b1, 64'h0, 48'h0, 1'b1},
        '{4'd8, 4'd2, OP_PACK_SIGNED, 48'h8000_0000_0000, 64'h0,
          1'b1, 64'h0, 48'h0, 1'b1},
        '{4'd8, 4'd2, OP_PACK_SIGNED, 48'h0000_0000_3333, 64'h0,
          1'b0, 64'h0, 48'h0, 1'b0},
        '{4'd8, 4'd2, OP_UNPACK_UNSIGNED, 48'hFFFF_FFFF_FFFF, 64'h150,
          1'b1, 64'h0, 48'h0000_0001_8000, 1'b0},
        '{4'd8, 4'd2, OP_UNPACK_SIGNED, 48'h0, 64'h1_0000_0150,
          1'b1, 64'h0, 48'hFFFF_FFFE_8000, 1'b0},
        // any nonzero sign nibble reads as negative
        '{4'd8, 4'd2, OP_UNPACK_SIGNED, 48'h0, 64'hF_0000_0150,
          1'b1, 64'h0, 48'hFFFF_FFFE_8000, 1'b0},
        // nibbles above the field are ignored
        '{4'd8, 4'd2, OP_UNPACK_UNSIGNED, 48'h0, 64'hFFFF_FFF0_0000_0150,
          1'b1, 64'h0, 48'h0000_0001_8000, 1'b0},
        // non-decimal nibbles weigh their binary value
        '{4'd8, 4'd2, OP_UNPACK_UNSIGNED, 48'h0, 64'h0000_0000_FFFF_FFFF,
          1'b0, 64'h0, 48'h0, 1'b0},
        '{4'd8, 4'd2, OP_UNPACK_SIGNED, 48'h0, 64'h0000_0000_9999_9999,
          1'b0, 64'h0, 48'h0, 1'b0},
        '{4'd8, 4'd2, OP_UNPACK_UNSIGNED, 48'h0, 64'h0,
          1'b1, 64'h0, 48'h0, 1'b0},
        // widest integer field: unpack saturates both ways
        '{4'd15, 4'd0, OP_UNPACK_UNSIGNED, 48'h0, 64'h0FFF_FFFF_FFFF_FFFF,
          1'b1, 64'h0, 48'h7FFF_FFFF_FFFF, 1'b1},
        '{4'd15, 4'd0, OP_UNPACK_SIGNED, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 64'h0, 48'h8000_0000_0000, 1'b1},
        '{4'd15, 4'd0, OP_PACK_UNSIGNED, 48'h7FFF_FFFF_FFFF, 64'h0,
          1'b0, 64'h0, 48'h0, 1'b0},
        '{4'd15, 4'd0, OP_PACK_SIGNED, 48'h8000_0000_0000, 64'h0,
          1'b0, 64'h0, 48'h0, 1'b0},
        // no digits at all
        '{4'd0, 4'd0, OP_PACK_UNSIGNED, 48'h0000_0000_8000, 64'h0,
          1'b1, 64'h0, 48'h0, 1'b0},
        '{4'd0, 4'd0, OP_PACK_UNSIGNED, 48'h0000_0001_0000, 64'h0,
          1'b1, 64'h0, 48'h0, 1'b1},
        '{4'd0, 4'd0, OP_PACK_SIGNED, 48'hFFFF_FFFF_8000, 64'h0,
          1'b1, 64'h1, 48'h0, 1'b0},
        // fraction longer than the field leaves no integer digits
        '{4'd4, 4'd9, OP_PACK_UNSIGNED, 48'h0000_0000_8000, 64'h0,
          1'b1, 64'h5000, 48'h0, 1'b0},
        '{4'd4, 4'd9, OP_UNPACK_UNSIGNED, 48'h0, 64'h5000,
          1'b1, 64'h0, 48'h0000_0000_8000, 1'b0},
        '{4'd15, 4'd15, OP_PACK_SIGNED, 48'hFFFF_FFFF_0001, 64'h0,
          1'b0, 64'h0, 48'h0, 1'b0}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [DATA_W-1:0]         s_tdata;     // fixed_value, bcd_in
    logic [1:0]                s_tuser;     // op
    logic                      m_tvalid;
    logic                      m_tready;
    logic [DATA_W-1:0]         m_tdata;     // bcd_out, value_out
    logic [0:0]                m_tuser;     // overflow

    // local copy of the digit registers, as the block should hold them
    logic [3:0] digit_setting    = 4'd8;
    logic [3:0] fraction_setting = 4'd2;

    codec_result_t expected_results [$];
    int            error_count  = 0;
    int            results_seen = 0;
    int            burst_left   = 0;
    int            idle_cycles  = 0;

    fixed_to_packed_bcd_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic logic [63:0] decimal_weight(int n);
        logic [63:0] w;
        w = 64'd1;
        for (int k = 0; k < n; k++) begin
            w = w * 64'd10;
        end
        return w;
    endfunction

    // digit count above the supported maximum acts as the maximum
    function automatic int active_digits();
        return (int'(digit_setting) > MAX_DIGIT) ? MAX_DIGIT : int'(digit_setting);
    endfunction

    // fraction wider than the field covers the whole field
    function automatic int active_fraction();
        return (int'(fraction_setting) > active_digits()) ? active_digits()
                                                          : int'(fraction_setting);
    endfunction

    function automatic codec_result_t bcd_from_fixed(logic [VALUE_W-1:0] raw,
                                                     bit signed_mode, int nd, int nf);
        codec_result_t      res;
        logic [VALUE_W-1:0] mag;
        logic [63:0]        ip;
        logic [63:0]        fr;
        int                 ni;
        res = '0;
        ni  = nd - nf;
        mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        // negative into unsigned never fits
        if (raw[VALUE_W-1] && !signed_mode) begin
            res.overflow = 1'b1;
            return res;
        end
        ip = 64'(mag) >> FRAC_W;
        fr = 64'(mag) & FRAC_MASK;
        if (ip >= decimal_weight(ni)) begin
            res.overflow = 1'b1;
            return res;
        end
        // integer digits sit just above the fraction digits
        for (int j = 0; j < ni; j++) begin
            res.bcd[(nf + j) * 4 +: 4] = 4'(ip % 64'd10);
            ip = ip / 64'd10;
        end
        // fraction digits by repeated times ten, truncated
        for (int j = 0; j < nf; j++) begin
            fr = fr * 64'd10;
            res.bcd[(nf - 1 - j) * 4 +: 4] = 4'(fr >> FRAC_W);
            fr = fr & FRAC_MASK;
        end
        if (signed_mode && raw[VALUE_W-1]) begin
            res.bcd[nd * 4 +: 4] = 4'd1;
        end
        return res;
    endfunction

    function automatic codec_result_t fixed_from_bcd(logic [BCD_BITS-1:0] word,
                                                     bit signed_mode, int nd, int nf);
        codec_result_t     res;
        logic [63:0]       ip;
        logic [63:0]       f;
        logic [63:0]       den;
        logic [63:0]       limit;
        logic [63:0]       mag;
        logic [FRAC_W-1:0] bits;
        bit                neg;
        int                ni;
        res  = '0;
        ni   = nd - nf;
        ip   = 64'd0;
        f    = 64'd0;
        bits = '0;
        den  = decimal_weight(nf);
        neg  = signed_mode && (word[nd * 4 +: 4] != 4'd0);
        for (int j = 0; j < nf; j++) begin
            f = f + 64'(word[j * 4 +: 4]) * decimal_weight(j);
        end
        for (int j = 0; j < ni; j++) begin
            ip = ip + 64'(word[(nf + j) * 4 +: 4]) * decimal_weight(j);
        end
        // non-decimal fraction nibbles can carry into the integer part
        ip = ip + f / den;
        f  = f % den;
        // binary fraction by long division, truncated
        for (int j = 0; j < FRAC_W; j++) begin
            f    = f << 1;
            bits = bits << 1;
            if (f >= den) begin
                f       = f - den;
                bits[0] = 1'b1;
            end
        end
        limit = neg ? SIGN_WEIGHT : SIGN_WEIGHT - 64'd1;
        if (ip > (limit >> FRAC_W)) begin
            mag          = limit;
            res.overflow = 1'b1;
        end else begin
            mag = (ip << FRAC_W) | 64'(bits);
            if (mag > limit) begin
                mag          = limit;
                res.overflow = 1'b1;
            end
        end
        res.value = neg ? VALUE_W'(~mag + 64'd1) : VALUE_W'(mag);
        return res;
    endfunction

    function automatic codec_result_t convert_request(codec_op_t op,
                                                      logic [VALUE_W-1:0] fixed_value,
                                                      logic [BCD_BITS-1:0] bcd_in);
        if (op == OP_PACK_UNSIGNED || op == OP_PACK_SIGNED) begin
            return bcd_from_fixed(fixed_value, op == OP_PACK_SIGNED,
                                  active_digits(), active_fraction());
        end
        return fixed_from_bcd(bcd_in, op == OP_UNPACK_SIGNED,
                              active_digits(), active_fraction());
    endfunction

    // ------------------------------------------------------------------------
    // random request content
    // ------------------------------------------------------------------------

    // mostly values that fit, some right at the digit limit, some raw noise
    function automatic logic [VALUE_W-1:0] random_fixed(int nd, int nf);
        logic [63:0]        whole;
        logic [VALUE_W-1:0] raw;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return VALUE_W'({$urandom, $urandom});
        end
        if (pick < 4) begin
            whole = decimal_weight(nd - nf) - 64'($urandom_range(0, 1));
        end else begin
            whole = {$urandom, $urandom} % decimal_weight(nd - nf);
        end
        raw = {1'b0, whole[30:0], 16'($urandom)};
        if ($urandom_range(0, 2) == 0) begin
            raw = ~raw + 1'b1;
        end
        return raw;
    endfunction

    // mostly decimal digits with a 0/1 sign nibble and noise above the field
    function automatic logic [BCD_BITS-1:0] random_bcd(int nd);
        logic [BCD_BITS-1:0] word;
        int                  pick;
        word = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            return word;
        end
        for (int k = 0; k < nd; k++) begin
            word[k * 4 +: 4] = (pick == 3) ? 4'd9 : 4'($urandom_range(0, 9));
        end
        word[nd * 4 +: 4] = 4'($urandom_range(0, 1));
        return word;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one request in bursts with random gaps; leaves s_tvalid high
    task automatic send_request(codec_op_t op, logic [VALUE_W-1:0] fixed_value,
                                logic [BCD_BITS-1:0] bcd_in, codec_result_t want);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {bcd_in, fixed_value};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(want);
        @(negedge aclk);
    endtask

    // leaves cfg_valid high so back-to-back writes do not toggle it
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (index == REG_DIGIT_COUNT) begin
            digit_setting = value;
        end else begin
            fraction_setting = value;
        end
        @(negedge aclk);
    endtask

    // only reconfigure once every outstanding result has come back
    task automatic reconfigure(logic [3:0] digits, logic [3:0] fraction);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        write_register(REG_DIGIT_COUNT, digits);
        write_register(REG_FRACTION_DIGITS, fraction);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // request side: reset, directed table, random phases, end of run
    // ------------------------------------------------------------------------
    initial begin
        codec_op_t           op;
        logic [VALUE_W-1:0]  fixed_value;
        logic [BCD_BITS-1:0] bcd_in;
        codec_result_t       want;
        logic [3:0]          digits;
        logic [3:0]          fraction;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table, first rows run on the reset setting
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            if (DIRECTED_ROWS[i].digits != digit_setting ||
                DIRECTED_ROWS[i].fraction != fraction_setting) begin
                reconfigure(DIRECTED_ROWS[i].digits, DIRECTED_ROWS[i].fraction);
            end
            if (DIRECTED_ROWS[i].known) begin
                want.bcd      = DIRECTED_ROWS[i].want_bcd;
                want.value    = DIRECTED_ROWS[i].want_value;
                want.overflow = DIRECTED_ROWS[i].want_overflow;
            end else begin
                want = convert_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].fixed_value,
                                       DIRECTED_ROWS[i].bcd_in);
            end
            send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].fixed_value,
                         DIRECTED_ROWS[i].bcd_in, want);
        end

        // random phases, extremes of the digit settings first
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    digits   = 4'd1;
                    fraction = 4'd0;
                end
                1: begin
                    digits   = 4'd15;
                    fraction = 4'd0;
                end
                2: begin
                    digits   = 4'd15;
                    fraction = 4'd15;
                end
                3: begin
                    digits   = 4'd0;
                    fraction = 4'd3;
                end
                default: begin
                    digits   = 4'($urandom_range(1, 15));
                    fraction = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(0, digits));
                end
            endcase
            reconfigure(digits, fraction);
            repeat (PHASE_REQUESTS) begin
                op          = codec_op_t'($urandom_range(0, 3));
                fixed_value = random_fixed(active_digits(), active_fraction());
                bcd_in      = random_bcd(active_digits());
                send_request(op, fixed_value, bcd_in,
                             convert_request(op, fixed_value, bcd_in));
            end
        end

        // drain, then give the block time to show any stray result
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("fixed_to_packed_bcd_codec regression: pass");
        end else begin
            $display("fixed_to_packed_bcd_codec regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: stall pattern, one long hold-off to back up the requests
    // ------------------------------------------------------------------------
    initial begin
        ready_style_t style;
        int           span;
        int           hold_left;
        int           tick;
        bit           hold_done;

        m_tready  = 1'b0;
        style     = READY_ALWAYS;
        span      = 0;
        hold_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (!hold_done && results_seen >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (span == 0) begin
                    style = ready_style_t'($urandom_range(0, 3));
                    span  = $urandom_range(16, 96);
                end
                span--;
                case (style)
                    READY_ALWAYS:   m_tready <= 1'b1;
                    READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:        m_tready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: oldest expectation against each accepted result
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        codec_result_t got;
        codec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.bcd      = m_tdata[BCD_BITS-1:0];
            got.value    = m_tdata[BCD_BITS +: VALUE_W];
            got.overflow = m_tuser[0];
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t ns: result with none expected, expected nothing actual %h",
                         $time, got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.bcd !== want.bcd) begin
                    $display("%0t ns: bcd_out mismatch, expected %h actual %h",
                             $time, want.bcd, got.bcd);
                    error_count++;
                end
                if (got.value !== want.value) begin
                    $display("%0t ns: value_out mismatch, expected %h actual %h",
                             $time, want.value, got.value);
                    error_count++;
                end
                if (got.overflow !== want.overflow) begin
                    $display("%0t ns: overflow mismatch, expected %b actual %b",
                             $time, want.overflow, got.overflow);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("fixed_to_packed_bcd_codec regression: fail");
            $finish;
        end
    end

endmodule
